FILE: src/nls_pkg.sv
package nls_pkg;

  localparam int CH_W    = 8;
  localparam int PHASE_W = 4;
  localparam int KIND_W  = 3;
  localparam int ERR_W   = 3;
  localparam int OUT_W   = 1 + 1 + KIND_W + ERR_W;

  typedef logic [CH_W-1:0]    char_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [ERR_W-1:0]   err_t;

  // scan phases
  localparam phase_t PH_IDLE     = 4'd0;
  localparam phase_t PH_ZERO     = 4'd1;
  localparam phase_t PH_PREFIX   = 4'd2;
  localparam phase_t PH_DIGITS   = 4'd3;
  localparam phase_t PH_FRAC     = 4'd4;
  localparam phase_t PH_AFTFRAC  = 4'd5;
  localparam phase_t PH_EXPSIGN  = 4'd6;
  localparam phase_t PH_EXPFIRST = 4'd7;
  localparam phase_t PH_EXPDIG   = 4'd8;
  localparam phase_t PH_INTSUF   = 4'd9;
  localparam phase_t PH_USEEN    = 4'd10;
  localparam phase_t PH_L1       = 4'd11;
  localparam phase_t PH_L2       = 4'd12;
  localparam phase_t PH_END      = 4'd13;
  localparam phase_t PH_FLTSUF   = 4'd14;

  // literal kinds
  localparam kind_t K_DEC  = 3'd0;
  localparam kind_t K_HEX  = 3'd1;
  localparam kind_t K_BIN  = 3'd2;
  localparam kind_t K_OCT  = 3'd3;
  localparam kind_t K_DECF = 3'd4;
  localparam kind_t K_HEXF = 3'd5;
  localparam kind_t K_FIX  = 3'd6;

  // error codes
  localparam err_t ERR_NONE      = 3'd0;
  localparam err_t ERR_NO_DIGIT  = 3'd1;
  localparam err_t ERR_EXP_EMPTY = 3'd2;
  localparam err_t ERR_TRAILING  = 3'd3;
  localparam err_t ERR_BAD_START = 3'd4;

  // longest chain of phases one character can pass through, plus margin
  localparam int SCAN_STEPS = 6;

  function automatic logic is_dig(input char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alnum_us(input char_t c);
    return is_dig(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
           || (c == "_");
  endfunction

  function automatic char_t to_low(input char_t c);
    return ((c >= "A") && (c <= "Z")) ? char_t'(c + 8'd32) : c;
  endfunction

  // digit of the base that the literal kind implies
  function automatic logic in_coll(input kind_t k, input char_t c);
    char_t l;
    logic  r;
    l = to_low(c);
    case (k)
      K_HEX, K_HEXF: r = is_dig(c) || ((l >= "a") && (l <= "f"));
      K_BIN:         r = (c == "0") || (c == "1");
      K_OCT:         r = (c >= "0") && (c <= "7");
      default:       r = is_dig(c);
    endcase
    return r;
  endfunction

endpackage

FILE: src/numeric_literal_scanner.sv
// Numeric literal scanner: takes one source character per transfer on the
// s_ side and returns one result per character on the m_ side, telling
// whether the character is part of a C-style numeric literal (consumed) or
// ends it (done, with the literal kind or an error code; that character is
// not consumed, so resend it as the start of whatever follows). A new
// literal starts with the first character after reset or after a done
// result. Set preproc_mode through cfg_we/cfg_wdata only while the block is
// idle; with it set, a letter, digit or '_' right after a literal is not an
// error. Throughput is one character per clock while m_tready stays high:
// the character is captured in an input register, the whole phase walk for
// it (at most four chained phase decisions) is evaluated combinationally,
// and the result lands in an output register. Backpressure on m_tready
// stalls the pipe; the input register refills in the same cycle the output
// register drains.
module numeric_literal_scanner (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,   // preproc_mode
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [nls_pkg::CH_W-1:0] s_tdata,     // [7:0] ch
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [nls_pkg::OUT_W-1:0] m_tdata     // [0] consumed, [1] done_res,
                                                // [4:2] literal_kind, [7:5] error_code
);
  import nls_pkg::*;

  // configuration
  logic   preproc_mode;

  // input register
  logic   in_valid;
  char_t  in_ch;

  // scanner state
  phase_t phase;
  kind_t  kind_so_far;
  logic   unsigned_seen;
  logic   long_char_upper;

  // per-character evaluation
  phase_t phase_next;
  kind_t  kind_so_far_next;
  logic   unsigned_seen_next;
  logic   long_char_upper_next;
  logic   cons_c;
  logic   done_c;
  kind_t  kind_c;
  err_t   err_c;
  logic   busy;
  char_t  low_ch;

  logic   adv;

  // advance the scan stage when a character waits and the result slot frees up
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      preproc_mode <= 1'b0;
    end else if (cfg_we) begin
      preproc_mode <= cfg_wdata;
    end
  end

  // capture the incoming character
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch <= s_tdata;
    end
  end

  // walk the phases for one character; each pass either settles the
  // character or hands it on to the next phase
  always_comb begin
    phase_next           = phase;
    kind_so_far_next     = kind_so_far;
    unsigned_seen_next   = unsigned_seen;
    long_char_upper_next = long_char_upper;
    cons_c               = 1'b0;
    done_c               = 1'b0;
    kind_c               = K_DEC;
    err_c                = ERR_NONE;
    low_ch               = to_low(in_ch);
    busy                 = 1'b1;
    for (int i = 0; i < SCAN_STEPS; i++) begin
      if (busy) begin
        busy = 1'b0;
        case (phase_next)
          PH_IDLE: begin
            if (in_ch == "0") begin
              cons_c = 1'b1;
              phase_next = PH_ZERO;
            end else if (is_dig(in_ch)) begin
              cons_c = 1'b1;
              phase_next = PH_DIGITS;
            end else if (in_ch == ".") begin
              cons_c = 1'b1;
              kind_so_far_next = K_DECF;
              phase_next = PH_FRAC;
            end else begin
              done_c = 1'b1;
              err_c = ERR_BAD_START;
            end
          end
          PH_ZERO: begin
            if (low_ch == "x") begin
              cons_c = 1'b1;
              kind_so_far_next = K_HEX;
              phase_next = PH_PREFIX;
            end else if (low_ch == "b") begin
              cons_c = 1'b1;
              kind_so_far_next = K_BIN;
              phase_next = PH_PREFIX;
            end else begin
              // 0e and 0. stay decimal, anything else means octal
              kind_so_far_next = (low_ch == "e" || in_ch == ".") ? K_DEC : K_OCT;
              phase_next = PH_DIGITS;
              busy = 1'b1;
            end
          end
          PH_PREFIX: begin
            if (in_coll(kind_so_far_next, in_ch)) begin
              cons_c = 1'b1;
              phase_next = PH_DIGITS;
            end else if (in_ch == ".") begin
              phase_next = PH_DIGITS;
              busy = 1'b1;
            end else begin
              done_c = 1'b1;
              err_c = ERR_NO_DIGIT;
            end
          end
          PH_DIGITS: begin
            if (in_coll(kind_so_far_next, in_ch) || in_ch == "'") begin
              cons_c = 1'b1;
            end else if ((kind_so_far_next == K_DEC &&
                          (in_ch == "." || low_ch == "e" || low_ch == "d")) ||
                         (kind_so_far_next == K_HEX && (in_ch == "." || low_ch == "p"))) begin
              kind_so_far_next = (kind_so_far_next == K_DEC) ? K_DECF : K_HEXF;
              if (in_ch == ".") begin
                cons_c = 1'b1;
                phase_next = PH_FRAC;
              end else begin
                phase_next = PH_AFTFRAC;
                busy = 1'b1;
              end
            end else begin
              phase_next = PH_INTSUF;
              busy = 1'b1;
            end
          end
          PH_FRAC: begin
            if (in_coll(kind_so_far_next, in_ch) || in_ch == "'") begin
              cons_c = 1'b1;
            end else begin
              phase_next = PH_AFTFRAC;
              busy = 1'b1;
            end
          end
          PH_AFTFRAC: begin
            if (kind_so_far_next == K_DECF && low_ch == "e") begin
              cons_c = 1'b1;
              phase_next = PH_EXPSIGN;
            end else if (kind_so_far_next == K_DECF && low_ch == "d") begin
              cons_c = 1'b1;
              kind_so_far_next = K_FIX;
              phase_next = PH_END;
            end else if (kind_so_far_next == K_HEXF && low_ch == "p") begin
              cons_c = 1'b1;
              phase_next = PH_EXPSIGN;
            end else begin
              phase_next = PH_FLTSUF;
              busy = 1'b1;
            end
          end
          PH_EXPSIGN: begin
            phase_next = PH_EXPFIRST;
            if (in_ch == "+" || in_ch == "-") begin
              cons_c = 1'b1;
            end else begin
              busy = 1'b1;
            end
          end
          PH_EXPFIRST: begin
            if (is_dig(in_ch)) begin
              cons_c = 1'b1;
              phase_next = PH_EXPDIG;
            end else begin
              done_c = 1'b1;
              err_c = ERR_EXP_EMPTY;
            end
          end
          PH_EXPDIG: begin
            if (is_dig(in_ch)) begin
              cons_c = 1'b1;
            end else begin
              phase_next = PH_FLTSUF;
              busy = 1'b1;
            end
          end
          PH_FLTSUF: begin
            phase_next = PH_END;
            if (low_ch == "f" || low_ch == "l") begin
              cons_c = 1'b1;
            end else begin
              busy = 1'b1;
            end
          end
          PH_INTSUF: begin
            if (low_ch == "u") begin
              cons_c = 1'b1;
              unsigned_seen_next = 1'b1;
              phase_next = PH_USEEN;
            end else if (low_ch == "l") begin
              cons_c = 1'b1;
              long_char_upper_next = (in_ch == "L");
              phase_next = PH_L1;
            end else begin
              phase_next = PH_END;
              busy = 1'b1;
            end
          end
          PH_USEEN: begin
            if (low_ch == "l") begin
              cons_c = 1'b1;
              long_char_upper_next = (in_ch == "L");
              phase_next = PH_L1;
            end else begin
              phase_next = PH_END;
              busy = 1'b1;
            end
          end
          PH_L1: begin
            // second l must match the case of the first
            phase_next = PH_L2;
            if (in_ch == (long_char_upper_next ? "L" : "l")) begin
              cons_c = 1'b1;
            end else begin
              busy = 1'b1;
            end
          end
          PH_L2: begin
            phase_next = PH_END;
            if (!unsigned_seen_next && low_ch == "u") begin
              cons_c = 1'b1;
            end else begin
              busy = 1'b1;
            end
          end
          default: begin
            // end of literal: judge the character that follows it
            done_c = 1'b1;
            if (!preproc_mode && is_alnum_us(in_ch)) begin
              err_c = ERR_TRAILING;
            end else begin
              kind_c = kind_so_far_next;
            end
          end
        endcase
      end
    end
    // a finished literal drops all state back to the reset values
    if (done_c) begin
      if (err_c != ERR_NONE) begin
        kind_c = K_DEC;
      end
      phase_next           = PH_IDLE;
      kind_so_far_next     = K_DEC;
      unsigned_seen_next   = 1'b0;
      long_char_upper_next = 1'b0;
    end
  end

  // advance scanner state once per evaluated character
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      kind_so_far     <= K_DEC;
      unsigned_seen   <= 1'b0;
      long_char_upper <= 1'b0;
    end else if (adv) begin
      phase           <= phase_next;
      kind_so_far     <= kind_so_far_next;
      unsigned_seen   <= unsigned_seen_next;
      long_char_upper <= long_char_upper_next;
    end
  end

  // result register; hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {err_c, kind_c, done_c, cons_c};
    end
  end

  // consumed and done never come together
  a_cons_done_excl: assert property (@(posedge clk) disable iff (rst)
    adv |-> !(cons_c && done_c))
    else $error("consumed and done in one result");

  // a consumed character carries no kind or error
  a_cons_clean: assert property (@(posedge clk) disable iff (rst)
    (adv && cons_c) |-> (kind_c == K_DEC && err_c == ERR_NONE))
    else $error("consumed result with kind or error");

  // every character settles within the chained passes
  a_settled: assert property (@(posedge clk) disable iff (rst)
    adv |-> (cons_c || done_c))
    else $error("character neither consumed nor ending the literal");

  // a finished literal restarts the scan from idle
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (adv && done_c) |=> (phase == PH_IDLE && kind_so_far == K_DEC &&
                         !unsigned_seen && !long_char_upper))
    else $error("state not cleared after a finished literal");

  // an error result reports no kind
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    (adv && err_c != ERR_NONE) |-> (done_c && kind_c == K_DEC))
    else $error("error without done or with a kind");

endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nls_pkg::*;

  // Generous ceiling: ~430 characters, sent in bursts behind random sender
  // gaps, and a receiver that may stall for whole stretches.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Let the two-stage pipe empty out before touching the mode register.
  localparam int SETTLE_CYCLES = 4;
  localparam int CHARS_PER_PHASE = 100;

  // One result as it sits on m_tdata: [0] consumed, [1] done, [4:2] kind, [7:5] error.
  typedef struct packed {
    err_t  err_code;
    kind_t lit_kind;
    logic  done;
    logic  consumed;
  } verdict_t;

  // Scoreboard: tracks the literal being scanned, predicts one verdict per
  // accepted character and checks the verdicts that come back, in order.
  class literal_scoreboard;
    bit       preproc;
    phase_t   scan_phase;
    kind_t    kind_acc;
    bit       unsigned_suffix;
    bit       long_upper;
    verdict_t pending_verdicts[$];
    int       mismatches;
    int       checked;

    function new();
      preproc = 1'b0;
      mismatches = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      scan_phase = PH_IDLE;
      kind_acc = K_DEC;
      unsigned_suffix = 1'b0;
      long_upper = 1'b0;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    function bit dec_digit(char_t c);
      return (c >= "0") && (c <= "9");
    endfunction

    // letters, digits and underscore; bytes from 0x80 up are none of these
    function bit word_char(char_t c);
      return dec_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
             || (c == "_");
    endfunction

    function char_t fold_case(char_t c);
      return ((c >= "A") && (c <= "Z")) ? char_t'(c + 8'd32) : c;
    endfunction

    function bit radix_digit(kind_t k, char_t c);
      char_t lc;
      lc = fold_case(c);
      case (k)
        K_HEX, K_HEXF: return dec_digit(c) || ((lc >= "a") && (lc <= "f"));
        K_BIN:         return (c == "0") || (c == "1");
        K_OCT:         return (c >= "0") && (c <= "7");
        default:       return dec_digit(c);
      endcase
    endfunction

    // Walk the scan phases for one character. A phase that does not take the
    // character hands it on to the next phase within the same step.
    function verdict_t scan_char(char_t c);
      char_t    lc;
      verdict_t v;
      bit       rerun;
      lc = fold_case(c);
      v = '0;
      do begin
        rerun = 1'b0;
        case (scan_phase)
          PH_IDLE: begin
            if (c == "0") begin
              v.consumed = 1'b1;
              scan_phase = PH_ZERO;
            end else if (dec_digit(c)) begin
              v.consumed = 1'b1;
              scan_phase = PH_DIGITS;
            end else if (c == ".") begin
              v.consumed = 1'b1;
              kind_acc = K_DECF;
              scan_phase = PH_FRAC;
            end else begin
              v.done = 1'b1;
              v.err_code = ERR_BAD_START;
            end
          end
          PH_ZERO: begin
            if (lc == "x") begin
              v.consumed = 1'b1;
              kind_acc = K_HEX;
              scan_phase = PH_PREFIX;
            end else if (lc == "b") begin
              v.consumed = 1'b1;
              kind_acc = K_BIN;
              scan_phase = PH_PREFIX;
            end else begin
              // 0e and 0. stay decimal, anything else makes it octal
              kind_acc = (lc == "e" || c == ".") ? K_DEC : K_OCT;
              scan_phase = PH_DIGITS;
              rerun = 1'b1;
            end
          end
          PH_PREFIX: begin
            if (radix_digit(kind_acc, c)) begin
              v.consumed = 1'b1;
              scan_phase = PH_DIGITS;
            end else if (c == ".") begin
              scan_phase = PH_DIGITS;
              rerun = 1'b1;
            end else begin
              v.done = 1'b1;
              v.err_code = ERR_NO_DIGIT;
            end
          end
          PH_DIGITS: begin
            if (radix_digit(kind_acc, c) || c == "'") begin
              v.consumed = 1'b1;
            end else if ((kind_acc == K_DEC && (c == "." || lc == "e" || lc == "d")) ||
                         (kind_acc == K_HEX && (c == "." || lc == "p"))) begin
              kind_acc = (kind_acc == K_DEC) ? K_DECF : K_HEXF;
              if (c == ".") begin
                v.consumed = 1'b1;
                scan_phase = PH_FRAC;
              end else begin
                scan_phase = PH_AFTFRAC;
                rerun = 1'b1;
              end
            end else begin
              scan_phase = PH_INTSUF;
              rerun = 1'b1;
            end
          end
          PH_FRAC: begin
            if (radix_digit(kind_acc, c) || c == "'") begin
              v.consumed = 1'b1;
            end else begin
              scan_phase = PH_AFTFRAC;
              rerun = 1'b1;
            end
          end
          PH_AFTFRAC: begin
            if (kind_acc == K_DECF && lc == "e") begin
              v.consumed = 1'b1;
              scan_phase = PH_EXPSIGN;
            end else if (kind_acc == K_DECF && lc == "d") begin
              v.consumed = 1'b1;
              kind_acc = K_FIX;
              scan_phase = PH_END;
            end else if (kind_acc == K_HEXF && lc == "p") begin
              v.consumed = 1'b1;
              scan_phase = PH_EXPSIGN;
            end else begin
              scan_phase = PH_FLTSUF;
              rerun = 1'b1;
            end
          end
          PH_EXPSIGN: begin
            if (c == "+" || c == "-") begin
              v.consumed = 1'b1;
            end else begin
              rerun = 1'b1;
            end
            scan_phase = PH_EXPFIRST;
          end
          PH_EXPFIRST: begin
            if (dec_digit(c)) begin
              v.consumed = 1'b1;
              scan_phase = PH_EXPDIG;
            end else begin
              v.done = 1'b1;
              v.err_code = ERR_EXP_EMPTY;
            end
          end
          PH_EXPDIG: begin
            if (dec_digit(c)) begin
              v.consumed = 1'b1;
            end else begin
              scan_phase = PH_FLTSUF;
              rerun = 1'b1;
            end
          end
          PH_FLTSUF: begin
            if (lc == "f" || lc == "l") begin
              v.consumed = 1'b1;
            end else begin
              rerun = 1'b1;
            end
            scan_phase = PH_END;
          end
          PH_INTSUF: begin
            if (lc == "u") begin
              v.consumed = 1'b1;
              unsigned_suffix = 1'b1;
              scan_phase = PH_USEEN;
            end else if (lc == "l") begin
              v.consumed = 1'b1;
              long_upper = (c == "L");
              scan_phase = PH_L1;
            end else begin
              scan_phase = PH_END;
              rerun = 1'b1;
            end
          end
          PH_USEEN: begin
            if (lc == "l") begin
              v.consumed = 1'b1;
              long_upper = (c == "L");
              scan_phase = PH_L1;
            end else begin
              scan_phase = PH_END;
              rerun = 1'b1;
            end
          end
          PH_L1: begin
            // the second l of ll must match the case of the first
            if (c == (long_upper ? "L" : "l")) begin
              v.consumed = 1'b1;
            end else begin
              rerun = 1'b1;
            end
            scan_phase = PH_L2;
          end
          PH_L2: begin
            if (!unsigned_suffix && lc == "u") begin
              v.consumed = 1'b1;
            end else begin
              rerun = 1'b1;
            end
            scan_phase = PH_END;
          end
          default: begin
            v.done = 1'b1;
            if (!preproc && word_char(c)) begin
              v.err_code = ERR_TRAILING;
            end else begin
              v.lit_kind = kind_acc;
            end
          end
        endcase
      end while (rerun);
      if (v.done) begin
        if (v.err_code != ERR_NONE) begin
          v.lit_kind = K_DEC;
        end
        restart();
      end
      return v;
    endfunction

    function void note_char(char_t c);
      pending_verdicts = {pending_verdicts, scan_char(c)};
    endfunction

    task report(string msg);
      $display("mismatch at result %0d: %s", checked, msg);
      mismatches++;
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("unexpected result 0x%02h", got));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.consumed !== want.consumed)
          report($sformatf("consumed %b, want %b", got.consumed, want.consumed));
        if (got.done !== want.done)
          report($sformatf("done %b, want %b", got.done, want.done));
        if (got.lit_kind !== want.lit_kind)
          report($sformatf("kind %0d, want %0d", got.lit_kind, want.lit_kind));
        if (got.err_code !== want.err_code)
          report($sformatf("error %0d, want %0d", got.err_code, want.err_code));
      end
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  char_t       s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  literal_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          sent_count = 0;

  numeric_literal_scanner u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_verdict(verdict_t'(m_tdata));
    end
  end

  // Receiver: stretches of steady ready, partial stalls and short full stops.
  initial begin : receiver
    int pct;
    int len;
    forever begin
      case ($urandom_range(0, 4))
        0, 1: begin
          pct = 100;
          len = $urandom_range(4, 40);
        end
        2: begin
          pct = 75;
          len = $urandom_range(4, 30);
        end
        3: begin
          pct = 35;
          len = $urandom_range(4, 30);
        end
        default: begin
          pct = 0;
          len = $urandom_range(1, 6);
        end
      endcase
      repeat (len) begin
        @(negedge clk);
        m_tready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  // Push one character through the slave side. Open a new burst after a
  // random gap once the old one is used up; a zero gap keeps valid high.
  task automatic send_char(input char_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        s_tdata <= char_t'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= c;
    do @(posedge clk); while (!s_tready);
    sb.note_char(c);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_seq(ref char_t seq[$]);
    foreach (seq[i]) send_char(seq[i]);
  endtask

  // Drop valid and wait for every predicted result, then let the pipe settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the mode register; call only from a falling edge with the block idle.
  task automatic write_mode(input logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.preproc = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_text(ref char_t seq[$], input string s);
    for (int i = 0; i < s.len(); i++) seq = {seq, char_t'(s[i])};
  endfunction

  function automatic void add_pick(ref char_t seq[$], input string pool);
    seq = {seq, char_t'(pool[$urandom_range(0, pool.len() - 1)])};
  endfunction

  // Digits of the given radix, with an occasional separator between them.
  function automatic void add_digits(ref char_t seq[$], input kind_t k, input int n);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) seq = {seq, char_t'("'")};
      case (k)
        K_HEX:   add_pick(seq, "0123456789abcdefABCDEF");
        K_BIN:   add_pick(seq, "01");
        K_OCT:   add_pick(seq, "01234567");
        default: add_pick(seq, "0123456789");
      endcase
    end
  endfunction

  function automatic void add_int_suffix(ref char_t seq[$]);
    string pool[$] = '{"", "", "u", "U", "l", "L", "ll", "LL", "ul", "Ul", "uLL", "lu",
                       "llU", "LLu", "lL", "Ll", "lll", "uu"};
    add_text(seq, pool[$urandom_range(0, pool.size() - 1)]);
  endfunction

  function automatic void add_flt_suffix(ref char_t seq[$]);
    string pool[$] = '{"", "", "f", "F", "l", "L", "ff"};
    add_text(seq, pool[$urandom_range(0, pool.size() - 1)]);
  endfunction

  // Exponent marker, optional sign, and sometimes no digits at all.
  function automatic void add_exponent(ref char_t seq[$], input string marks);
    add_pick(seq, marks);
    if ($urandom_range(0, 1)) add_pick(seq, "+-");
    add_digits(seq, K_DEC, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3));
  endfunction

  // One random literal of a random shape, followed by a terminator; now and
  // then just a few raw bytes instead.
  function automatic void add_literal(ref char_t seq[$]);
    string zero_forms[$] = '{"0", "0e1", "0.5", "0x.", "0b.", "0E+", "0'7", "0X.p1", "0d"};
    int n;
    case ($urandom_range(0, 9))
      0: begin
        add_pick(seq, "123456789");
        add_digits(seq, K_DEC, $urandom_range(0, 4));
        add_int_suffix(seq);
      end
      1: begin
        add_text(seq, "0");
        add_pick(seq, "xX");
        add_digits(seq, K_HEX, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4));
        add_int_suffix(seq);
      end
      2: begin
        add_text(seq, "0");
        add_pick(seq, "bB");
        add_digits(seq, K_BIN, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 5));
        add_int_suffix(seq);
      end
      3: begin
        add_text(seq, "0");
        add_digits(seq, K_OCT, $urandom_range(0, 4));
        if ($urandom_range(0, 4) == 0) add_pick(seq, "89");
        add_int_suffix(seq);
      end
      4: begin
        // zero integer digits gives the lone-dot form
        add_digits(seq, K_DEC, $urandom_range(0, 3));
        add_text(seq, ".");
        add_digits(seq, K_DEC, $urandom_range(0, 3));
        if ($urandom_range(0, 1)) add_exponent(seq, "eE");
        add_flt_suffix(seq);
      end
      5: begin
        add_pick(seq, "123456789");
        add_digits(seq, K_DEC, $urandom_range(0, 2));
        add_exponent(seq, "eE");
        add_flt_suffix(seq);
      end
      6: begin
        add_text(seq, "0");
        add_pick(seq, "xX");
        add_digits(seq, K_HEX, $urandom_range(0, 3));
        if ($urandom_range(0, 1)) begin
          add_text(seq, ".");
          add_digits(seq, K_HEX, $urandom_range(0, 2));
        end
        add_exponent(seq, "pP");
        add_flt_suffix(seq);
      end
      7: begin
        add_pick(seq, "123456789");
        add_digits(seq, K_DEC, $urandom_range(0, 2));
        if ($urandom_range(0, 1)) begin
          add_text(seq, ".");
          add_digits(seq, K_DEC, $urandom_range(0, 2));
        end
        add_pick(seq, "dD");
      end
      8: add_text(seq, zero_forms[$urandom_range(0, zero_forms.size() - 1)]);
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) seq = {seq, char_t'($urandom)};
        return;
      end
    endcase
    case ($urandom_range(0, 9))
      0: add_text(seq, " ");
      1: add_text(seq, ";");
      2: seq = {seq, char_t'(8'h00)};
      3: add_pick(seq, "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ");
      4: add_text(seq, "_");
      5: seq = {seq, char_t'($urandom)};
      6: add_text(seq, ")");
      7: add_text(seq, ",");
      8: add_pick(seq, "0123456789");
      default: add_text(seq, "L");
    endcase
  endfunction

  initial begin : stimulus
    char_t seq[$];
    int    phase_start;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_mode(1'b0);

    // Directed: high byte as a bad start, 0x hitting end of text, lone dot
    // with exponent and a trailing underscore, octal cut by 8, mixed-case
    // long, 0b ended by a dot, hex fraction with signed exponent, and an
    // exponent with no digit.
    seq = {seq, char_t'(8'hFF)};
    add_text(seq, "0x");
    seq = {seq, char_t'(8'h00)};
    add_text(seq, ".e5_081lL0b.0x.Ap+1 1e+;");
    send_seq(seq);
    drain();

    // Random phases, alternating the mode so both settings see every shape.
    for (int p = 0; p < 4; p++) begin
      write_mode((p % 2) == 0);
      phase_start = sent_count;
      while (sent_count - phase_start < CHARS_PER_PHASE) begin
        seq.delete();
        add_literal(seq);
        send_seq(seq);
      end
      drain();
    end

    // Keep the clock running before the verdict so a stray extra result still gets caught.
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: numeric_literal_scanner.f
src/nls_pkg.sv
src/numeric_literal_scanner.sv
test/tb_top.sv
